### rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants for the FIR rectify moving-average unit.
// ----------------------------------------------------------------------------
package fra_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STAMP_W  = 32;
    localparam int ACC_W    = 32;
    localparam int ENV_W    = 15;
    localparam int TAPIDX_W = 5;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef struct packed {
        logic                       shift;
        logic                       rotate;
        logic                       load;
        logic [TAPIDX_W-1:0]        tap_index;
        logic signed [SAMPLE_W-1:0] tap_value;
    } cell_ctl_t;

    typedef struct packed {
        logic             busy;
        logic [ENV_W-1:0] average;
    } avg_status_t;

endpackage

### rtl/fra_cell.sv
// ----------------------------------------------------------------------------
// fra_cell
// One filter tap: holds a sample, its stamp and the tap coefficient.
// ----------------------------------------------------------------------------
module fra_cell #(
    parameter int INDEX = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fra_pkg::cell_ctl_t                  ctl,
    input  logic signed [fra_pkg::SAMPLE_W-1:0] prev_sample,
    input  logic [fra_pkg::STAMP_W-1:0]         prev_stamp,
    input  logic signed [fra_pkg::SAMPLE_W-1:0] next_sample,
    input  logic signed [fra_pkg::SAMPLE_W-1:0] next_coef,
    output logic signed [fra_pkg::SAMPLE_W-1:0] sample,
    output logic signed [fra_pkg::SAMPLE_W-1:0] coef,
    output logic [fra_pkg::STAMP_W-1:0]         stamp
);
    import fra_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] coef_reg;
    logic [STAMP_W-1:0]         stamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            coef_reg   <= '0;
            stamp_reg  <= '0;
        end else begin
            if (ctl.shift) begin
                sample_reg <= prev_sample;
                stamp_reg  <= prev_stamp;
            end else if (ctl.rotate) begin
                sample_reg <= next_sample;
                coef_reg   <= next_coef;
            end
            if (ctl.load && (int'(ctl.tap_index) == INDEX)) begin
                coef_reg <= ctl.tap_value;
            end
        end
    end

    assign sample = sample_reg;
    assign coef   = coef_reg;
    assign stamp  = stamp_reg;

endmodule

### rtl/fra_avg.sv
// ----------------------------------------------------------------------------
// fra_avg
// Running-sum window average: a bit-serial restoring divider by the fill count
// while the window fills, a reciprocal multiply by the window size once full.
// ----------------------------------------------------------------------------
module fra_avg #(
    parameter int AVG_WINDOW = 49
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fra_pkg::ENV_W-1:0]   value,
    output fra_pkg::avg_status_t        status
);
    import fra_pkg::*;

    localparam int FW  = $clog2(AVG_WINDOW + 1);
    localparam int PW  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int TW  = ENV_W + FW;
    localparam int DCW = $clog2(TW + 1);
    localparam int RS  = TW + PW;
    localparam longint RECIP_L = ((longint'(1) << RS) + longint'(AVG_WINDOW) - longint'(1))
                                 / longint'(AVG_WINDOW);
    localparam logic [RS:0] RECIP = (RS+1)'(RECIP_L);

    typedef enum logic [2:0] {A_IDLE, A_READ, A_UPDATE, A_SCALE, A_DIV} astate_t;

    astate_t           state_reg;
    logic [ENV_W-1:0]  window_mem [AVG_WINDOW];
    logic [ENV_W-1:0]  old_reg;
    logic [ENV_W-1:0]  value_reg;
    logic [PW-1:0]     wptr_reg;
    logic [FW-1:0]     fill_reg;
    logic [TW-1:0]     total_reg;
    logic [FW-1:0]     div_reg;
    logic [TW-1:0]     quo_reg;
    logic [FW:0]       rem_reg;
    logic [DCW-1:0]    dcnt_reg;
    logic [FW:0]       rem_shift;
    logic [TW+RS:0]    scale_prod;

    assign rem_shift  = {rem_reg[FW-1:0], quo_reg[TW-1]};
    assign scale_prod = total_reg * RECIP;

    always_ff @(posedge aclk) begin
        if (state_reg == A_IDLE && start && fill_reg == FW'(AVG_WINDOW)) begin
            old_reg <= window_mem[wptr_reg];
        end
        if (state_reg == A_IDLE && start && fill_reg != FW'(AVG_WINDOW)) begin
            window_mem[fill_reg[PW-1:0]] <= value;
        end else if (state_reg == A_UPDATE) begin
            window_mem[wptr_reg] <= value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            wptr_reg  <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
            dcnt_reg  <= '0;
        end else begin
            case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        value_reg <= value;
                        if (fill_reg != FW'(AVG_WINDOW)) begin
                            total_reg <= total_reg + TW'(value);
                            fill_reg  <= fill_reg + 1'b1;
                            div_reg   <= fill_reg + 1'b1;
                            quo_reg   <= total_reg + TW'(value);
                            rem_reg   <= '0;
                            dcnt_reg  <= '0;
                            state_reg <= A_DIV;
                        end else begin
                            state_reg <= A_READ;
                        end
                    end
                end
                A_READ: begin
                    state_reg <= A_UPDATE;
                end
                A_UPDATE: begin
                    total_reg <= total_reg + TW'(value_reg) - TW'(old_reg);
                    if (wptr_reg == PW'(AVG_WINDOW - 1)) begin
                        wptr_reg <= '0;
                    end else begin
                        wptr_reg <= wptr_reg + 1'b1;
                    end
                    state_reg <= A_SCALE;
                end
                A_SCALE: begin
                    quo_reg   <= scale_prod[RS+TW-1:RS];
                    state_reg <= A_IDLE;
                end
                A_DIV: begin
                    if (rem_shift >= {1'b0, div_reg}) begin
                        rem_reg <= rem_shift - {1'b0, div_reg};
                        quo_reg <= {quo_reg[TW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[TW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCW'(TW - 1)) begin
                        state_reg <= A_IDLE;
                    end
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign status.busy    = (state_reg != A_IDLE);
    assign status.average = quo_reg[ENV_W-1:0];

endmodule

### rtl/fir_rectify_moving_average_unit.sv
// ----------------------------------------------------------------------------
// fir_rectify_moving_average_unit
// FIR filter over a chain of tap cells, rectifier and window average.
// ----------------------------------------------------------------------------
// A sample item rotates the chain past one multiplier in S_MAC, then is drained,
// rectified and averaged: window update and reciprocal scale once the window is
// full, a bit-serial divide by the fill count while it fills. A new item is taken
// only in S_IDLE, after the last result is registered, and waits while a result
// waits on m_ready; a coefficient item is taken in S_IDLE without leaving it.
// Reset: synchronous active low; clears control state and cells, not datapath regs.
module fir_rectify_moving_average_unit #(
    parameter int TAPS       = 32,
    parameter int AVG_WINDOW = 49
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic signed [fra_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [fra_pkg::STAMP_W-1:0]         s_stamp,
    input  logic [fra_pkg::TAPIDX_W-1:0]        s_tap_index,
    input  logic signed [fra_pkg::SAMPLE_W-1:0] s_tap_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fra_pkg::ENV_W-1:0]           m_envelope,
    output logic [fra_pkg::STAMP_W-1:0]         m_delayed_stamp
);
    import fra_pkg::*;

    localparam int CW = $clog2(TAPS + 1);

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_RECT, S_WAIT, S_OUT} state_t;

    state_t                     state_reg;
    logic [CW-1:0]              cnt_reg;
    logic signed [ACC_W-1:0]    prod_reg;
    logic                       prod_vld_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic                       m_valid_reg;
    logic [ENV_W-1:0]           env_reg;
    logic [STAMP_W-1:0]         dstamp_reg;

    logic                       accept;
    cell_ctl_t                  ctl;
    avg_status_t                avg_st;
    logic                       avg_start;
    logic signed [SAMPLE_W-1:0] sample_w [TAPS];
    logic signed [SAMPLE_W-1:0] coef_w   [TAPS];
    logic [STAMP_W-1:0]         stamp_w  [TAPS];

    logic signed [SAMPLE_W-1:0] sh;
    logic signed [SAMPLE_W:0]   half;
    logic signed [SAMPLE_W:0]   mag;
    logic [ENV_W-1:0]           rect;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    assign ctl.shift     = accept && (s_mode == MODE_SAMPLE);
    assign ctl.load      = accept && (s_mode == MODE_COEF);
    assign ctl.rotate    = (state_reg == S_MAC);
    assign ctl.tap_index = s_tap_index;
    assign ctl.tap_value = s_tap_value;

    for (genvar i = 0; i < TAPS; i++) begin : g_cell
        fra_cell #(.INDEX(i)) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .prev_sample ((i == 0) ? s_sample : sample_w[(i + TAPS - 1) % TAPS]),
            .prev_stamp  ((i == 0) ? s_stamp : stamp_w[(i + TAPS - 1) % TAPS]),
            .next_sample (sample_w[(i + 1) % TAPS]),
            .next_coef   (coef_w[(i + 1) % TAPS]),
            .sample      (sample_w[i]),
            .coef        (coef_w[i]),
            .stamp       (stamp_w[i])
        );
    end

    always_comb begin
        sh   = acc_reg[ACC_W-1:ACC_W-SAMPLE_W];
        half = $signed({sh[SAMPLE_W-1], sh} + (SAMPLE_W+1)'(sh[SAMPLE_W-1])) >>> 1;
        mag  = half[SAMPLE_W] ? -half : half;
        rect = mag[ENV_W-1:0];
    end

    assign avg_start = (state_reg == S_RECT);

    fra_avg #(.AVG_WINDOW(AVG_WINDOW)) u_avg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (avg_start),
        .value   (rect),
        .status  (avg_st)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= sample_w[0] * coef_w[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            prod_vld_reg <= (state_reg == S_MAC);
            if (prod_vld_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (ctl.shift) begin
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(TAPS - 1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: state_reg <= S_RECT;
                S_RECT:  state_reg <= S_WAIT;
                S_WAIT: begin
                    if (!avg_st.busy) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        env_reg     <= avg_st.average;
                        dstamp_reg  <= stamp_w[TAPS-1];
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_envelope      = env_reg;
    assign m_delayed_stamp = dstamp_reg;

endmodule
